/* rtl/core/rti_pkg.sv */
// rti_pkg: shared widths, codes, the multiply-accumulate program and the
// command and status structs of the ray/triangle intersection block.
// It depends on nothing else.
package rti_pkg;

  localparam int CoordBits  = 32;
  localparam int TagBits    = 16;
  localparam int DistBits   = 32;
  localparam int CfgIdxBits = 8;
  localparam int EdgeBits   = CoordBits + 1;
  localparam int MulBits    = EdgeBits + 1;
  localparam int WideBits   = 108;
  localparam int DivBits    = WideBits + 16;
  localparam int CntBits    = $clog2(DivBits);
  localparam int PcBits     = 6;

  localparam logic [PcBits-1:0] PcSdetLast = 6'd8;
  localparam logic [PcBits-1:0] PcQvFirst  = 6'd9;
  localparam logic [PcBits-1:0] PcDenLast  = 6'd23;
  localparam logic [PcBits-1:0] PcUuFirst  = 6'd24;
  localparam logic [PcBits-1:0] PcVvLast   = 6'd29;
  localparam logic [PcBits-1:0] PcNumFirst = 6'd30;
  localparam logic [PcBits-1:0] PcNumLast  = 6'd32;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_ORIGIN_X    = 8'd0,
    REG_ORIGIN_Y    = 8'd1,
    REG_ORIGIN_Z    = 8'd2,
    REG_DIRECTION_X = 8'd3,
    REG_DIRECTION_Y = 8'd4,
    REG_DIRECTION_Z = 8'd5,
    REG_NEAR_LIMIT  = 8'd6,
    REG_FAR_LIMIT   = 8'd7
  } cfg_reg_e;

  typedef enum logic [4:0] {
    A_EAB0, A_EAB1, A_EAB2, A_EAC0, A_EAC1, A_EAC2, A_TV0, A_TV1, A_TV2,
    A_DIR0, A_DIR1, A_DIR2, A_NRM0, A_NRM1, A_NRM2, A_PV0, A_PV1, A_PV2,
    A_QV0, A_QV1, A_QV2
  } a_sel_e;

  typedef enum logic [3:0] {
    B_EAB0, B_EAB1, B_EAB2, B_EAC0, B_EAC1, B_EAC2, B_TV0, B_TV1, B_TV2,
    B_DIR0, B_DIR1, B_DIR2
  } b_sel_e;

  typedef enum logic [3:0] {
    D_NONE, D_NRM0, D_NRM1, D_NRM2, D_PV0, D_PV1, D_PV2, D_QV0, D_QV1, D_QV2,
    D_SDET, D_DEN, D_UU, D_VV, D_NUM
  } dst_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_STEP, ST_WRITE, ST_SWAP, ST_CHK_DEN, ST_CHK_UV,
    ST_DIV_INIT, ST_DIV, ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    a_sel_e a_sel;
    b_sel_e b_sel;
    logic   sub;
    logic   first;
    dst_e   dst;
  } uop_t;

  typedef struct packed {
    logic accept;
    logic mac_load;
    logic mac_step;
    logic write;
    logic swap;
    logic div_init;
    logic div_step;
    logic finish;
    logic geom_ok;
    uop_t uop;
  } rti_cmd_t;

  typedef struct packed {
    logic sdet_pos;
    logic den_pos;
    logic uv_ok;
    logic out_free;
  } rti_status_t;

  typedef struct packed {
    logic                        command;
    logic                        new_ray;
    logic [TagBits-1:0]          tri_tag;
    logic signed [CoordBits-1:0] vertex_a_x;
    logic signed [CoordBits-1:0] vertex_a_y;
    logic signed [CoordBits-1:0] vertex_a_z;
    logic signed [CoordBits-1:0] vertex_b_x;
    logic signed [CoordBits-1:0] vertex_b_y;
    logic signed [CoordBits-1:0] vertex_b_z;
    logic signed [CoordBits-1:0] vertex_c_x;
    logic signed [CoordBits-1:0] vertex_c_y;
    logic signed [CoordBits-1:0] vertex_c_z;
  } rti_tri_t;

  function automatic uop_t mk(a_sel_e a, b_sel_e b, logic sub, logic first, dst_e d);
    uop_t u;
    u.a_sel = a;
    u.b_sel = b;
    u.sub   = sub;
    u.first = first;
    u.dst   = d;
    return u;
  endfunction

  // Cross products are two terms, dot products three; the last term of each
  // group names the register that takes the sum.
  function automatic uop_t uop_at(logic [PcBits-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(A_EAB1, B_EAC2, 1'b0, 1'b1, D_NONE);
      6'd1:  u = mk(A_EAB2, B_EAC1, 1'b1, 1'b0, D_NRM0);
      6'd2:  u = mk(A_EAB2, B_EAC0, 1'b0, 1'b1, D_NONE);
      6'd3:  u = mk(A_EAB0, B_EAC2, 1'b1, 1'b0, D_NRM1);
      6'd4:  u = mk(A_EAB0, B_EAC1, 1'b0, 1'b1, D_NONE);
      6'd5:  u = mk(A_EAB1, B_EAC0, 1'b1, 1'b0, D_NRM2);
      6'd6:  u = mk(A_NRM0, B_DIR0, 1'b0, 1'b1, D_NONE);
      6'd7:  u = mk(A_NRM1, B_DIR1, 1'b0, 1'b0, D_NONE);
      6'd8:  u = mk(A_NRM2, B_DIR2, 1'b0, 1'b0, D_SDET);
      6'd9:  u = mk(A_TV1,  B_EAB2, 1'b0, 1'b1, D_NONE);
      6'd10: u = mk(A_TV2,  B_EAB1, 1'b1, 1'b0, D_QV0);
      6'd11: u = mk(A_TV2,  B_EAB0, 1'b0, 1'b1, D_NONE);
      6'd12: u = mk(A_TV0,  B_EAB2, 1'b1, 1'b0, D_QV1);
      6'd13: u = mk(A_TV0,  B_EAB1, 1'b0, 1'b1, D_NONE);
      6'd14: u = mk(A_TV1,  B_EAB0, 1'b1, 1'b0, D_QV2);
      6'd15: u = mk(A_DIR1, B_EAC2, 1'b0, 1'b1, D_NONE);
      6'd16: u = mk(A_DIR2, B_EAC1, 1'b1, 1'b0, D_PV0);
      6'd17: u = mk(A_DIR2, B_EAC0, 1'b0, 1'b1, D_NONE);
      6'd18: u = mk(A_DIR0, B_EAC2, 1'b1, 1'b0, D_PV1);
      6'd19: u = mk(A_DIR0, B_EAC1, 1'b0, 1'b1, D_NONE);
      6'd20: u = mk(A_DIR1, B_EAC0, 1'b1, 1'b0, D_PV2);
      6'd21: u = mk(A_PV0,  B_EAB0, 1'b0, 1'b1, D_NONE);
      6'd22: u = mk(A_PV1,  B_EAB1, 1'b0, 1'b0, D_NONE);
      6'd23: u = mk(A_PV2,  B_EAB2, 1'b0, 1'b0, D_DEN);
      6'd24: u = mk(A_PV0,  B_TV0,  1'b0, 1'b1, D_NONE);
      6'd25: u = mk(A_PV1,  B_TV1,  1'b0, 1'b0, D_NONE);
      6'd26: u = mk(A_PV2,  B_TV2,  1'b0, 1'b0, D_UU);
      6'd27: u = mk(A_QV0,  B_DIR0, 1'b0, 1'b1, D_NONE);
      6'd28: u = mk(A_QV1,  B_DIR1, 1'b0, 1'b0, D_NONE);
      6'd29: u = mk(A_QV2,  B_DIR2, 1'b0, 1'b0, D_VV);
      6'd30: u = mk(A_QV0,  B_EAC0, 1'b0, 1'b1, D_NONE);
      6'd31: u = mk(A_QV1,  B_EAC1, 1'b0, 1'b0, D_NONE);
      6'd32: u = mk(A_QV2,  B_EAC2, 1'b0, 1'b0, D_NUM);
      default: u = mk(A_EAB0, B_EAB0, 1'b0, 1'b1, D_NONE);
    endcase
    return u;
  endfunction

endpackage

/* rtl/core/rti_channels.sv */
// Handshake channels of the ray/triangle intersection block: triangle input,
// result output and configuration write. Depends on rti_pkg for widths.
interface rti_tri_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic                                 new_ray;
  logic [rti_pkg::TagBits-1:0]          tri_tag;
  logic signed [rti_pkg::CoordBits-1:0] vertex_a_x;
  logic signed [rti_pkg::CoordBits-1:0] vertex_a_y;
  logic signed [rti_pkg::CoordBits-1:0] vertex_a_z;
  logic signed [rti_pkg::CoordBits-1:0] vertex_b_x;
  logic signed [rti_pkg::CoordBits-1:0] vertex_b_y;
  logic signed [rti_pkg::CoordBits-1:0] vertex_b_z;
  logic signed [rti_pkg::CoordBits-1:0] vertex_c_x;
  logic signed [rti_pkg::CoordBits-1:0] vertex_c_y;
  logic signed [rti_pkg::CoordBits-1:0] vertex_c_z;
  modport source (output valid, command, new_ray, tri_tag, vertex_a_x, vertex_a_y,
                  vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z, vertex_c_x,
                  vertex_c_y, vertex_c_z, input ready);
  modport sink (input valid, command, new_ray, tri_tag, vertex_a_x, vertex_a_y,
                vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z, vertex_c_x,
                vertex_c_y, vertex_c_z, output ready);
endinterface

interface rti_res_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic signed [rti_pkg::DistBits-1:0] hit_distance;
  logic [15:0]                         hit_tag;
  modport source (output valid, hit, hit_distance, hit_tag, input ready);
  modport sink (input valid, hit, hit_distance, hit_tag, output ready);
endinterface

interface rti_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rti_pkg::CfgIdxBits-1:0]   index;
  logic [31:0]                      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/ray_triangle_intersect_top.sv */
// Ray/triangle intersection, one triangle at a time against a configured ray.
// The time from transfer of a triangle to its result is longest on a full
// test and shorter when the determinant or barycentric test rejects early.
// A new triangle is taken only after the previous result is posted; the
// bit-serial 34-bit multiply loop (33 products) and 124-step divider dominate.
// Reset (rst_ni low, asynchronous): controller idle, result empty, ray and
// limits to their defaults, kept closest distance to the largest value.
module ray_triangle_intersect_top (
  input  logic clk_i,
  input  logic rst_ni,
  rti_cfg_if.sink   cfg_i,
  rti_tri_if.sink   tri_i,
  rti_res_if.source res_o
);

  rti_pkg::rti_cmd_t    cmd;
  rti_pkg::rti_status_t status;
  rti_pkg::rti_tri_t    tri_data;

  // Configuration is always taken; a write to an index past the last
  // register has no effect.
  assign cfg_i.ready = 1'b1;

  // Gather the triangle payload into one struct for the datapath. The
  // datapath samples it only on the transfer cycle.
  assign tri_data.command    = tri_i.command;
  assign tri_data.new_ray    = tri_i.new_ray;
  assign tri_data.tri_tag    = tri_i.tri_tag;
  assign tri_data.vertex_a_x = tri_i.vertex_a_x;
  assign tri_data.vertex_a_y = tri_i.vertex_a_y;
  assign tri_data.vertex_a_z = tri_i.vertex_a_z;
  assign tri_data.vertex_b_x = tri_i.vertex_b_x;
  assign tri_data.vertex_b_y = tri_i.vertex_b_y;
  assign tri_data.vertex_b_z = tri_i.vertex_b_z;
  assign tri_data.vertex_c_x = tri_i.vertex_c_x;
  assign tri_data.vertex_c_y = tri_i.vertex_c_y;
  assign tri_data.vertex_c_z = tri_i.vertex_c_z;

  // The controller walks the product program, the swap and the two early
  // rejection checks, then the divider, and finally posts the result into
  // the output register. Because the result sits in its own register, the
  // next triangle can be taken while the previous result still waits.
  rti_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (tri_i.valid),
    .in_ready_o (tri_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rti_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .tri_i       (tri_data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_hit_o   (res_o.hit),
    .out_dist_o  (res_o.hit_distance),
    .out_tag_o   (res_o.hit_tag)
  );

endmodule

/* rtl/core/rti_ctrl.sv */
// rti_ctrl: sequencer of the intersection test. It steps the shared
// multiply-accumulate unit through the program in rti_pkg, then the divider.
module rti_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rti_pkg::rti_status_t status_i,
  output rti_pkg::rti_cmd_t    cmd_o
);

  rti_pkg::ctrl_state_e              state_q, state_d;
  logic [rti_pkg::PcBits-1:0]        pc_q, pc_d;
  logic [rti_pkg::CntBits-1:0]       cnt_q, cnt_d;
  logic                              ok_q, ok_d;
  rti_pkg::uop_t                     uop;

  assign uop = rti_pkg::uop_at(pc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rti_pkg::ST_IDLE;
      pc_q    <= '0;
      cnt_q   <= '0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      cnt_q   <= cnt_d;
      ok_q    <= ok_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    cnt_d       = cnt_q;
    ok_d        = ok_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.uop   = uop;
    cmd_o.geom_ok = ok_q;
    case (state_q)
      rti_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          pc_d    = '0;
          ok_d    = 1'b0;
          state_d = rti_pkg::ST_LOAD;
        end
      end
      rti_pkg::ST_LOAD: begin
        cmd_o.mac_load = 1'b1;
        cnt_d   = '0;
        state_d = rti_pkg::ST_STEP;
      end
      rti_pkg::ST_STEP: begin
        cmd_o.mac_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == rti_pkg::CntBits'(rti_pkg::MulBits - 1)) begin
          if (uop.dst != rti_pkg::D_NONE) begin
            state_d = rti_pkg::ST_WRITE;
          end else begin
            pc_d    = pc_q + 1'b1;
            state_d = rti_pkg::ST_LOAD;
          end
        end
      end
      rti_pkg::ST_WRITE: begin
        cmd_o.write = 1'b1;
        pc_d = pc_q + 1'b1;
        if (pc_q == rti_pkg::PcSdetLast) begin
          state_d = rti_pkg::ST_SWAP;
        end else if (pc_q == rti_pkg::PcDenLast) begin
          state_d = rti_pkg::ST_CHK_DEN;
        end else if (pc_q == rti_pkg::PcVvLast) begin
          state_d = rti_pkg::ST_CHK_UV;
        end else if (pc_q == rti_pkg::PcNumLast) begin
          state_d = rti_pkg::ST_DIV_INIT;
        end else begin
          state_d = rti_pkg::ST_LOAD;
        end
      end
      rti_pkg::ST_SWAP: begin
        cmd_o.swap = status_i.sdet_pos;
        pc_d    = rti_pkg::PcQvFirst;
        state_d = rti_pkg::ST_LOAD;
      end
      rti_pkg::ST_CHK_DEN: begin
        pc_d    = rti_pkg::PcUuFirst;
        state_d = status_i.den_pos ? rti_pkg::ST_LOAD : rti_pkg::ST_FINISH;
      end
      rti_pkg::ST_CHK_UV: begin
        pc_d    = rti_pkg::PcNumFirst;
        state_d = status_i.uv_ok ? rti_pkg::ST_LOAD : rti_pkg::ST_FINISH;
      end
      rti_pkg::ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d   = '0;
        state_d = rti_pkg::ST_DIV;
      end
      rti_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == rti_pkg::CntBits'(rti_pkg::DivBits - 1)) begin
          ok_d    = 1'b1;
          state_d = rti_pkg::ST_FINISH;
        end
      end
      rti_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = rti_pkg::ST_IDLE;
        end
      end
      default: state_d = rti_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/rti_datapath.sv */
// rti_datapath: ray registers, edge and product registers, the shared
// bit-serial multiply-accumulate unit, the restoring divider and the result
// register. Controlled by rti_ctrl through rti_pkg::rti_cmd_t.
module rti_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rti_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [31:0]                         cfg_data_i,
  input  rti_pkg::rti_tri_t                   tri_i,
  input  rti_pkg::rti_cmd_t                   cmd_i,
  output rti_pkg::rti_status_t                status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_hit_o,
  output logic signed [rti_pkg::DistBits-1:0] out_dist_o,
  output logic [15:0]                         out_tag_o
);

  localparam int EB = rti_pkg::EdgeBits;
  localparam int WB = rti_pkg::WideBits;
  localparam int MB = rti_pkg::MulBits;
  localparam int CB = rti_pkg::CoordBits;
  localparam int DB = rti_pkg::DistBits;

  function automatic logic signed [EB-1:0] ext_e(input logic signed [CB-1:0] v);
    return {v[CB-1], v};
  endfunction

  function automatic logic signed [WB-1:0] wide_e(input logic signed [EB-1:0] v);
    return {{(WB-EB){v[EB-1]}}, v};
  endfunction

  function automatic logic signed [MB-1:0] mul_e(input logic signed [EB-1:0] v);
    return {{(MB-EB){v[EB-1]}}, v};
  endfunction

  // Ray configuration.
  logic signed [CB-1:0] org_q [3];
  logic signed [CB-1:0] dir_q [3];
  logic signed [DB-1:0] near_q, far_q, closest_q;

  // Per-triangle values.
  logic                          op_q;
  logic [rti_pkg::TagBits-1:0]   tag_q;
  logic signed [EB-1:0]          eab_q [3];
  logic signed [EB-1:0]          eac_q [3];
  logic signed [EB-1:0]          tv_q [3];
  logic signed [WB-1:0]          nrm_q [3];
  logic signed [WB-1:0]          pv_q [3];
  logic signed [WB-1:0]          qv_q [3];
  logic signed [WB-1:0]          sdet_q, den_q, uu_q, vv_q, num_q;

  // Multiply-accumulate unit.
  logic signed [WB-1:0]          acc_q, ash_q;
  logic [MB-1:0]                 bmag_q;
  logic                          bsub_q;
  logic signed [WB-1:0]          a_val;
  logic signed [MB-1:0]          b_val;
  logic [MB-1:0]                 b_mag;

  // Divider.
  logic [rti_pkg::DivBits-1:0]   m_q;
  logic [WB-1:0]                 rem_q;
  logic [DB:0]                   quo_q;
  logic                          ovf_q, neg_q;
  logic [WB-1:0]                 num_mag, rem_sh;
  logic                          rem_ge;

  logic signed [DB-1:0]          t_sat;
  logic                          hit;
  logic signed [WB-1:0]          uv_sum;

  logic                          out_valid_q, out_hit_q;
  logic signed [DB-1:0]          out_dist_q;
  logic [15:0]                   out_tag_q;

  always_comb begin
    case (cmd_i.uop.a_sel)
      rti_pkg::A_EAB0: a_val = wide_e(eab_q[0]);
      rti_pkg::A_EAB1: a_val = wide_e(eab_q[1]);
      rti_pkg::A_EAB2: a_val = wide_e(eab_q[2]);
      rti_pkg::A_EAC0: a_val = wide_e(eac_q[0]);
      rti_pkg::A_EAC1: a_val = wide_e(eac_q[1]);
      rti_pkg::A_EAC2: a_val = wide_e(eac_q[2]);
      rti_pkg::A_TV0:  a_val = wide_e(tv_q[0]);
      rti_pkg::A_TV1:  a_val = wide_e(tv_q[1]);
      rti_pkg::A_TV2:  a_val = wide_e(tv_q[2]);
      rti_pkg::A_DIR0: a_val = wide_e(ext_e(dir_q[0]));
      rti_pkg::A_DIR1: a_val = wide_e(ext_e(dir_q[1]));
      rti_pkg::A_DIR2: a_val = wide_e(ext_e(dir_q[2]));
      rti_pkg::A_NRM0: a_val = nrm_q[0];
      rti_pkg::A_NRM1: a_val = nrm_q[1];
      rti_pkg::A_NRM2: a_val = nrm_q[2];
      rti_pkg::A_PV0:  a_val = pv_q[0];
      rti_pkg::A_PV1:  a_val = pv_q[1];
      rti_pkg::A_PV2:  a_val = pv_q[2];
      rti_pkg::A_QV0:  a_val = qv_q[0];
      rti_pkg::A_QV1:  a_val = qv_q[1];
      rti_pkg::A_QV2:  a_val = qv_q[2];
      default:         a_val = '0;
    endcase
    case (cmd_i.uop.b_sel)
      rti_pkg::B_EAB0: b_val = mul_e(eab_q[0]);
      rti_pkg::B_EAB1: b_val = mul_e(eab_q[1]);
      rti_pkg::B_EAB2: b_val = mul_e(eab_q[2]);
      rti_pkg::B_EAC0: b_val = mul_e(eac_q[0]);
      rti_pkg::B_EAC1: b_val = mul_e(eac_q[1]);
      rti_pkg::B_EAC2: b_val = mul_e(eac_q[2]);
      rti_pkg::B_TV0:  b_val = mul_e(tv_q[0]);
      rti_pkg::B_TV1:  b_val = mul_e(tv_q[1]);
      rti_pkg::B_TV2:  b_val = mul_e(tv_q[2]);
      rti_pkg::B_DIR0: b_val = mul_e(ext_e(dir_q[0]));
      rti_pkg::B_DIR1: b_val = mul_e(ext_e(dir_q[1]));
      rti_pkg::B_DIR2: b_val = mul_e(ext_e(dir_q[2]));
      default:         b_val = '0;
    endcase
    b_mag = b_val[MB-1] ? MB'(-b_val) : MB'(b_val);
  end

  // Divider: one quotient bit per cycle.
  assign num_mag = num_q[WB-1] ? WB'(-num_q) : WB'(num_q);
  assign rem_sh  = {rem_q[WB-2:0], m_q[rti_pkg::DivBits-1]};
  assign rem_ge  = (rem_sh >= den_q);

  // Quotient saturated to the signed distance range.
  always_comb begin
    if (ovf_q || quo_q[DB] || quo_q[DB-1]) begin
      t_sat = neg_q ? {1'b1, {(DB-1){1'b0}}} : {1'b0, {(DB-1){1'b1}}};
    end else begin
      t_sat = neg_q ? DB'(-quo_q[DB-1:0]) : quo_q[DB-1:0];
    end
  end

  assign hit    = cmd_i.geom_ok && (t_sat >= near_q) && (t_sat <= closest_q);
  assign uv_sum = uu_q + vv_q;

  assign status_o.sdet_pos = !sdet_q[WB-1] && (sdet_q != '0);
  assign status_o.den_pos  = !den_q[WB-1] && (den_q != '0);
  assign status_o.uv_ok    = !uu_q[WB-1] && !vv_q[WB-1] && (uv_sum <= den_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0]    <= '0;
      org_q[1]    <= '0;
      org_q[2]    <= '0;
      dir_q[0]    <= '0;
      dir_q[1]    <= '0;
      dir_q[2]    <= 32'sh0001_0000;
      near_q      <= '0;
      far_q       <= 32'sh7FFF_FFFF;
      closest_q   <= 32'sh7FFF_FFFF;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          rti_pkg::REG_ORIGIN_X:    org_q[0] <= cfg_data_i;
          rti_pkg::REG_ORIGIN_Y:    org_q[1] <= cfg_data_i;
          rti_pkg::REG_ORIGIN_Z:    org_q[2] <= cfg_data_i;
          rti_pkg::REG_DIRECTION_X: dir_q[0] <= cfg_data_i;
          rti_pkg::REG_DIRECTION_Y: dir_q[1] <= cfg_data_i;
          rti_pkg::REG_DIRECTION_Z: dir_q[2] <= cfg_data_i;
          rti_pkg::REG_NEAR_LIMIT:  near_q   <= cfg_data_i;
          rti_pkg::REG_FAR_LIMIT:   far_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.accept && tri_i.new_ray) begin
        closest_q <= far_q;
      end else if (cmd_i.finish && hit && !op_q) begin
        closest_q <= t_sat;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= tri_i.command;
      tag_q    <= tri_i.tri_tag;
      eab_q[0] <= ext_e(tri_i.vertex_b_x) - ext_e(tri_i.vertex_a_x);
      eab_q[1] <= ext_e(tri_i.vertex_b_y) - ext_e(tri_i.vertex_a_y);
      eab_q[2] <= ext_e(tri_i.vertex_b_z) - ext_e(tri_i.vertex_a_z);
      eac_q[0] <= ext_e(tri_i.vertex_c_x) - ext_e(tri_i.vertex_a_x);
      eac_q[1] <= ext_e(tri_i.vertex_c_y) - ext_e(tri_i.vertex_a_y);
      eac_q[2] <= ext_e(tri_i.vertex_c_z) - ext_e(tri_i.vertex_a_z);
      tv_q[0]  <= ext_e(org_q[0]) - ext_e(tri_i.vertex_a_x);
      tv_q[1]  <= ext_e(org_q[1]) - ext_e(tri_i.vertex_a_y);
      tv_q[2]  <= ext_e(org_q[2]) - ext_e(tri_i.vertex_a_z);
    end
    if (cmd_i.swap) begin
      eab_q <= eac_q;
      eac_q <= eab_q;
    end
    if (cmd_i.mac_load) begin
      if (cmd_i.uop.first) begin
        acc_q <= '0;
      end
      ash_q  <= a_val;
      bmag_q <= b_mag;
      bsub_q <= cmd_i.uop.sub ^ b_val[MB-1];
    end
    if (cmd_i.mac_step) begin
      if (bmag_q[0]) begin
        acc_q <= bsub_q ? (acc_q - ash_q) : (acc_q + ash_q);
      end
      ash_q  <= ash_q <<< 1;
      bmag_q <= bmag_q >> 1;
    end
    if (cmd_i.write) begin
      case (cmd_i.uop.dst)
        rti_pkg::D_NRM0: nrm_q[0] <= acc_q;
        rti_pkg::D_NRM1: nrm_q[1] <= acc_q;
        rti_pkg::D_NRM2: nrm_q[2] <= acc_q;
        rti_pkg::D_PV0:  pv_q[0]  <= acc_q;
        rti_pkg::D_PV1:  pv_q[1]  <= acc_q;
        rti_pkg::D_PV2:  pv_q[2]  <= acc_q;
        rti_pkg::D_QV0:  qv_q[0]  <= acc_q;
        rti_pkg::D_QV1:  qv_q[1]  <= acc_q;
        rti_pkg::D_QV2:  qv_q[2]  <= acc_q;
        rti_pkg::D_SDET: sdet_q   <= acc_q;
        rti_pkg::D_DEN:  den_q    <= acc_q;
        rti_pkg::D_UU:   uu_q     <= acc_q;
        rti_pkg::D_VV:   vv_q     <= acc_q;
        rti_pkg::D_NUM:  num_q    <= acc_q;
        default: ;
      endcase
    end
    if (cmd_i.div_init) begin
      m_q   <= {num_mag, 16'h0000};
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
      neg_q <= num_q[WB-1];
    end
    if (cmd_i.div_step) begin
      m_q   <= m_q << 1;
      rem_q <= rem_ge ? (rem_sh - den_q) : rem_sh;
      quo_q <= {quo_q[DB-1:0], rem_ge};
      ovf_q <= ovf_q | quo_q[DB];
    end
    if (cmd_i.finish) begin
      out_hit_q  <= hit;
      out_dist_q <= hit ? t_sat : '0;
      out_tag_q  <= 16'(tag_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_hit_o   = out_hit_q;
  assign out_dist_o  = out_dist_q;
  assign out_tag_o   = out_tag_q;

endmodule

/* rtl/core/rti_checker.sv */
// rti_checker: port-level assertions for ray_triangle_intersect_top, bound
// to the top level below. Depends on rti_pkg for widths.
module rti_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                tri_valid_i,
  input logic                                tri_ready_i,
  input logic                                res_valid_i,
  input logic                                res_ready_i,
  input logic                                res_hit_i,
  input logic signed [rti_pkg::DistBits-1:0] res_dist_i
);

  // A result waiting on the output holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped before transfer");

  // A miss reports zero distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_hit_i |-> res_dist_i == '0)
    else $error("miss with nonzero distance");

  // One triangle at a time: input closes right after a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tri_valid_i && tri_ready_i |=> !tri_ready_i)
    else $error("second triangle taken while busy");

  // No result appears in the cycle after a triangle transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tri_valid_i && tri_ready_i && !res_valid_i |=> !res_valid_i)
    else $error("result appeared too early");

endmodule

bind ray_triangle_intersect_top rti_checker u_rti_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .tri_valid_i (tri_i.valid),
  .tri_ready_i (tri_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_hit_i   (res_o.hit),
  .res_dist_i  (res_o.hit_distance)
);
